### rtl/dkls_pkg.sv
// Shared types, constants and codes of the dense keyframe blend sampler.
package dkls_pkg;

   // Default sizes of the frame table and of a clip.
   localparam int DEF_TABLE_WORDS = 16384;
   localparam int DEF_MAX_CURVES  = 64;
   localparam int DEF_MAX_FRAMES  = 1024;

   // Fixed field widths.
   localparam int VALUE_W    = 32;
   localparam int WADDR_W    = 14;
   localparam int CURVE_W    = 6;
   localparam int WEIGHT_W   = 16;
   localparam int FTOTAL_W   = 11;
   localparam int CCOUNT_W   = 7;
   localparam int CSR_IDX_W  = 2;

   // Request tdata layout, lowest bit first.
   localparam int REQ_ADDR_LSB  = 0;
   localparam int REQ_VALUE_LSB = REQ_ADDR_LSB + WADDR_W;
   localparam int REQ_TIME_LSB  = REQ_VALUE_LSB + VALUE_W;
   localparam int REQ_USED_W    = REQ_TIME_LSB + VALUE_W;
   localparam int REQ_DATA_W    = ((REQ_USED_W + 7) / 8) * 8;

   // Register reset values.
   localparam logic [VALUE_W-1:0]  RST_START_TIME = 32'd0;
   localparam logic [VALUE_W-1:0]  RST_FPS        = 32'd1966080;
   localparam logic [FTOTAL_W-1:0] RST_FTOTAL     = 11'd2;
   localparam logic [CCOUNT_W-1:0] RST_CCOUNT     = 7'd1;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_TIME = 2'd0,
      CSR_FPS        = 2'd1,
      CSR_FTOTAL     = 2'd2,
      CSR_CCOUNT     = 2'd3
   } csr_idx_type;

   // Request operation codes.
   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   // Sample sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_CLAMP,
      ST_BASE,
      ST_ISSUE
   } state_type;

   // Control that travels with each table read pair.
   typedef struct packed {
      logic                valid;
      logic [CURVE_W-1:0]  curve;
      logic                last;
      logic                oob_a;
      logic                oob_b;
      logic [WEIGHT_W-1:0] weight;
   } tag_type;

endpackage

### rtl/dkls_ram.sv
// Generic RAM with one write port and two registered read ports.
module dkls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_a_ff <= mem_ff[raddr_a];
         rdata_b_ff <= mem_ff[raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

### rtl/dkls_blend.sv
// Blend pipeline: neighbor difference, weight multiply, rounding and output register.
module dkls_blend (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  dkls_pkg::tag_type             tag,
   input  logic [dkls_pkg::VALUE_W-1:0]  rdata_a,
   input  logic [dkls_pkg::VALUE_W-1:0]  rdata_b,
   output logic                          out_valid,
   output logic [dkls_pkg::CURVE_W-1:0]  out_curve,
   output logic [dkls_pkg::VALUE_W-1:0]  out_value,
   output logic                          out_last
);

   import dkls_pkg::*;

   localparam int DIFF_W = VALUE_W + 1;
   localparam int PROD_W = DIFF_W + WEIGHT_W + 1;

   // Stage 1: tag aligned with the registered table reads.
   tag_type tag1_ff;

   // Stage 2: left value and neighbor difference.
   logic                       valid2_ff;
   logic [CURVE_W-1:0]         curve2_ff;
   logic                       last2_ff;
   logic [WEIGHT_W-1:0]        weight2_ff;
   logic signed [VALUE_W-1:0]  a2_ff;
   logic signed [DIFF_W-1:0]   diff2_ff;

   // Stage 3: weighted difference.
   logic                       valid3_ff;
   logic [CURVE_W-1:0]         curve3_ff;
   logic                       last3_ff;
   logic signed [VALUE_W-1:0]  a3_ff;
   logic signed [PROD_W-1:0]   prod3_ff;

   // Stage 4: result register.
   logic                       valid4_ff;
   logic [CURVE_W-1:0]         curve4_ff;
   logic                       last4_ff;
   logic [VALUE_W-1:0]         value4_ff;

   logic signed [VALUE_W-1:0]  a_in;
   logic signed [VALUE_W-1:0]  b_in;
   logic signed [DIFF_W-1:0]   diff_in;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [PROD_W-1:0]   rounded;
   logic signed [PROD_W-1:0]   shifted;
   logic [VALUE_W-1:0]         value_in;

   // An address beyond the table reads as zero.
   assign a_in    = tag1_ff.oob_a ? '0 : $signed(rdata_a);
   assign b_in    = tag1_ff.oob_b ? '0 : $signed(rdata_b);
   assign diff_in = $signed({b_in[VALUE_W-1], b_in}) - $signed({a_in[VALUE_W-1], a_in});
   assign prod_in = diff2_ff * $signed({1'b0, weight2_ff});

   // Round half up, then floor: the arithmetic shift floors toward minus infinity.
   assign rounded  = prod3_ff + PROD_W'(32768);
   assign shifted  = rounded >>> WEIGHT_W;
   assign value_in = a3_ff + shifted[VALUE_W-1:0];

   // Only the valid bits are cleared by reset; the data moves with them.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         valid2_ff     <= 1'b0;
         valid3_ff     <= 1'b0;
         valid4_ff     <= 1'b0;
      end else if (advance) begin
         tag1_ff   <= tag;
         valid2_ff <= tag1_ff.valid;
         valid3_ff <= valid2_ff;
         valid4_ff <= valid3_ff;

         curve2_ff  <= tag1_ff.curve;
         last2_ff   <= tag1_ff.last;
         weight2_ff <= tag1_ff.weight;
         a2_ff      <= a_in;
         diff2_ff   <= diff_in;

         curve3_ff <= curve2_ff;
         last3_ff  <= last2_ff;
         a3_ff     <= a2_ff;
         prod3_ff  <= prod_in;

         curve4_ff <= curve3_ff;
         last4_ff  <= last3_ff;
         value4_ff <= value_in;
      end
   end

   assign out_valid = valid4_ff;
   assign out_curve = curve4_ff;
   assign out_value = value4_ff;
   assign out_last  = last4_ff;

endmodule

### rtl/dense_keyframe_lerp_sampler.sv
// Top level of the dense keyframe sampler: frame table, sample sequencer and blend pipeline.
//
// The block keeps a table of uniformly spaced animation frames, one signed Q16.16 value per
// curve and frame, stored at word frame * curves_per_frame + curve. Items arrive on the req_
// stream. An item with req_tuser low writes req word_value into the table at word_address and
// returns nothing; an address beyond the table is dropped. An item with req_tuser high samples
// the clip at sample_time and returns one item per curve on the rsp_ stream, curve number in
// rsp_tuser, the blended value in rsp_tdata, and rsp_tlast on the final curve.
// A write item is stored when it is taken. A sample item occupies the request side through its
// setup steps (time difference, the 32 x 32 position multiply, frame clamp, row base multiply)
// and then while the table is read for each curve in turn. The two table words of each curve
// come from the dual-read table memory together; that read port sets the rate of one result
// per cycle unless the receiver stalls. The first result passes the setup registers, the
// registered table read and the blend stages before it leaves. When the receiver holds
// rsp_tready low, the whole blend pipeline and the table read freeze and nothing is lost. A new
// item is taken as soon as the last curve address of a sample has been read, while its results
// still drain. Synchronous reset clears the sequencer and pipeline valid bits and reloads the
// configuration registers; the table contents are undefined until written. The csr_ port writes
// a register and must only be used while the block is idle.
module dense_keyframe_lerp_sampler #(
   parameter int TABLE_WORDS = dkls_pkg::DEF_TABLE_WORDS,
   parameter int MAX_CURVES  = dkls_pkg::DEF_MAX_CURVES,
   parameter int MAX_FRAMES  = dkls_pkg::DEF_MAX_FRAMES
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request stream.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata fields from bit 0: word_address[13:0], word_value[45:14], sample_time[77:46], pad.
   input  logic [dkls_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser fields from bit 0: operation.
   input  logic                            req_tuser,
   // Result stream.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tdata fields from bit 0: blended_value[31:0].
   output logic [dkls_pkg::VALUE_W-1:0]    rsp_tdata,
   // tuser fields from bit 0: curve_number[5:0].
   output logic [dkls_pkg::CURVE_W-1:0]    rsp_tuser,
   output logic                            rsp_tlast,
   // Configuration write port.
   input  logic                            csr_we,
   input  logic [dkls_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dkls_pkg::VALUE_W-1:0]    csr_wdata
);

   import dkls_pkg::*;

   localparam int ADDR_W  = $clog2(TABLE_WORDS);
   localparam int FRAME_W = $clog2(MAX_FRAMES);
   localparam int NC_W    = $clog2(MAX_CURVES + 1);
   localparam int CI_W    = (MAX_CURVES > 1) ? $clog2(MAX_CURVES) : 1;
   localparam int SUM_W   = FRAME_W + NC_W;
   localparam int LIN_W   = (SUM_W > ADDR_W + 1) ? SUM_W : ADDR_W + 1;

   // Configuration registers.
   logic [VALUE_W-1:0]  start_time_ff;
   logic [VALUE_W-1:0]  fps_ff;
   logic [FTOTAL_W-1:0] ftotal_ff;
   logic [CCOUNT_W-1:0] ccount_ff;

   // Sequencer.
   state_type state_ff;
   state_type state_in;
   logic      req_ready_c;
   logic      issue_c;

   // Sample setup registers.
   logic signed [VALUE_W:0]  diff_ff;
   logic [2*VALUE_W-1:0]     pos_ff;
   logic                     neg_ff;
   logic [FRAME_W-1:0]       left_ff;
   logic [FRAME_W-1:0]       right_ff;
   logic [WEIGHT_W-1:0]      weight_ff;
   logic [LIN_W-1:0]         addr_a_ff;
   logic [LIN_W-1:0]         addr_b_ff;
   logic [CI_W-1:0]          cnt_ff;

   // Request fields.
   op_type              req_op;
   logic [WADDR_W-1:0]  req_waddr;
   logic [VALUE_W-1:0]  req_wvalue;
   logic [VALUE_W-1:0]  req_time;
   logic                req_accept;
   logic                wr_in_range;
   logic                ram_we;

   // Clamped clip sizes.
   logic [31:0]         ft_wide;
   logic [31:0]         nf_wide;
   logic [31:0]         nc_wide;
   logic [31:0]         whole;
   logic [NC_W-1:0]     nc;
   logic [CI_W-1:0]     last_idx;
   logic                last_c;

   logic signed [VALUE_W:0]  diff_in;
   logic [2*VALUE_W-1:0]     pos_in;
   logic [SUM_W-1:0]         base_a;
   logic [SUM_W-1:0]         base_b;

   logic                advance;
   tag_type             tag;
   logic [VALUE_W-1:0]  rdata_a;
   logic [VALUE_W-1:0]  rdata_b;

   assign req_op     = op_type'(req_tuser);
   assign req_waddr  = req_tdata[REQ_ADDR_LSB +: WADDR_W];
   assign req_wvalue = req_tdata[REQ_VALUE_LSB +: VALUE_W];
   assign req_time   = req_tdata[REQ_TIME_LSB +: VALUE_W];
   assign req_accept = req_tvalid && req_ready_c;

   assign wr_in_range = 32'(req_waddr) < 32'(TABLE_WORDS);
   assign ram_we      = req_accept && (req_op == OP_WRITE) && wr_in_range;

   // The whole blend pipeline moves only when the result register can take a new item.
   assign advance = !rsp_tvalid || rsp_tready;

   // Frame count saturates into 1..MAX_FRAMES, curve count into 1..MAX_CURVES.
   assign ft_wide  = 32'(ftotal_ff);
   assign nf_wide  = (ft_wide == 32'd0) ? 32'd1 :
                     (ft_wide > 32'(MAX_FRAMES)) ? 32'(MAX_FRAMES) : ft_wide;
   assign nc_wide  = (ccount_ff == '0) ? 32'd1 :
                     (32'(ccount_ff) > 32'(MAX_CURVES)) ? 32'(MAX_CURVES) : 32'(ccount_ff);
   assign nc       = NC_W'(nc_wide);
   assign last_idx = CI_W'(nc_wide - 32'd1);
   assign last_c   = (cnt_ff == last_idx);

   assign whole  = pos_ff[2*VALUE_W-1:VALUE_W];
   assign diff_in = $signed({req_time[VALUE_W-1], req_time})
                  - $signed({start_time_ff[VALUE_W-1], start_time_ff});
   assign pos_in = diff_ff[VALUE_W-1:0] * fps_ff;
   assign base_a = left_ff * nc;
   assign base_b = right_ff * nc;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_time_ff <= RST_START_TIME;
         fps_ff        <= RST_FPS;
         ftotal_ff     <= RST_FTOTAL;
         ccount_ff     <= RST_CCOUNT;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_START_TIME: start_time_ff <= csr_wdata;
            CSR_FPS:        fps_ff        <= csr_wdata;
            CSR_FTOTAL:     ftotal_ff     <= csr_wdata[FTOTAL_W-1:0];
            CSR_CCOUNT:     ccount_ff     <= csr_wdata[CCOUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && (req_op == OP_SAMPLE)) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT:  state_in = ST_CLAMP;
         ST_CLAMP: state_in = ST_BASE;
         ST_BASE:  state_in = ST_ISSUE;
         ST_ISSUE: begin
            if (advance && last_c) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready_c = 1'b0;
      issue_c     = 1'b0;
      case (state_ff)
         ST_IDLE:  req_ready_c = 1'b1;
         ST_ISSUE: issue_c     = 1'b1;
         default: ;
      endcase
   end

   // Sample setup and address walk. Times before the start hold frame 0 with zero weight; a
   // left frame at or past the last stored frame holds the last frame.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               diff_ff <= diff_in;
            end
         end
         ST_MULT: begin
            pos_ff <= pos_in;
            neg_ff <= diff_ff[VALUE_W];
         end
         ST_CLAMP: begin
            if (neg_ff) begin
               left_ff   <= '0;
               right_ff  <= '0;
               weight_ff <= '0;
            end else begin
               weight_ff <= pos_ff[VALUE_W-1:WEIGHT_W];
               if (whole >= nf_wide - 32'd1) begin
                  left_ff  <= FRAME_W'(nf_wide - 32'd1);
                  right_ff <= FRAME_W'(nf_wide - 32'd1);
               end else begin
                  left_ff  <= whole[FRAME_W-1:0];
                  right_ff <= whole[FRAME_W-1:0] + FRAME_W'(1);
               end
            end
         end
         ST_BASE: begin
            addr_a_ff <= LIN_W'(base_a);
            addr_b_ff <= LIN_W'(base_b);
            cnt_ff    <= '0;
         end
         ST_ISSUE: begin
            if (advance) begin
               addr_a_ff <= addr_a_ff + LIN_W'(1);
               addr_b_ff <= addr_b_ff + LIN_W'(1);
               cnt_ff    <= cnt_ff + CI_W'(1);
            end
         end
         default: ;
      endcase
   end

   // Control that rides along with the current read pair.
   always_comb begin
      tag.valid  = issue_c;
      tag.curve  = CURVE_W'(cnt_ff);
      tag.last   = last_c;
      tag.oob_a  = addr_a_ff >= LIN_W'(TABLE_WORDS);
      tag.oob_b  = addr_b_ff >= LIN_W'(TABLE_WORDS);
      tag.weight = weight_ff;
   end

   dkls_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TABLE_WORDS)
   ) u_table (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (ADDR_W'(req_waddr)),
      .wdata   (req_wvalue),
      .re      (advance),
      .raddr_a (addr_a_ff[ADDR_W-1:0]),
      .raddr_b (addr_b_ff[ADDR_W-1:0]),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

   dkls_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .tag       (tag),
      .rdata_a   (rdata_a),
      .rdata_b   (rdata_b),
      .out_valid (rsp_tvalid),
      .out_curve (rsp_tuser),
      .out_value (rsp_tdata),
      .out_last  (rsp_tlast)
   );

   assign req_tready = req_ready_c;

endmodule

### tb/dense_keyframe_lerp_sampler_test.sv
// Self-checking testbench for the dense keyframe sampler: directed script, then random phases.
module dense_keyframe_lerp_sampler_test;
   import dkls_pkg::*;

   // The block is built with its default sizes, so the shadow table matches them.
   localparam int TABLE_WORDS = DEF_TABLE_WORDS;
   // A write item retires when it is taken and the first blend passes the sample setup, table
   // read and blend stages, so this many quiet cycles means the block has nothing in flight.
   localparam int SETTLE_CYCLES = 12;
   // Cycles without any handshake before the run is declared hung. The long receiver
   // hold-off below is far shorter than this limit, so the limit leaves a wide margin.
   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_OFF_CYCLES = 400;
   // Items to send over the whole run, table fills included.
   localparam int TOTAL_ITEMS = 270;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [VALUE_W-1:0]     rsp_tdata;
   logic [CURVE_W-1:0]     rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [VALUE_W-1:0]     csr_wdata;

   // One blended curve value as it should appear on the result stream.
   typedef struct {
      logic [CURVE_W-1:0] curve;
      logic [VALUE_W-1:0] value;
      logic               last;
   } blend_type;

   // Blends predicted for accepted samples, oldest first.
   blend_type due_blends[$];

   // Shadow copy of the frame table and of the configuration registers.
   logic [VALUE_W-1:0]  shadow_table [TABLE_WORDS];
   bit                  written [TABLE_WORDS];
   logic [VALUE_W-1:0]  cfg_start  = RST_START_TIME;
   logic [VALUE_W-1:0]  cfg_fps    = RST_FPS;
   logic [FTOTAL_W-1:0] cfg_frames = RST_FTOTAL;
   logic [CCOUNT_W-1:0] cfg_curves = RST_CCOUNT;

   int error_count = 0;
   int items_sent = 0;
   bit hold_off_request = 0;
   bit sender_steady = 0;

   dense_keyframe_lerp_sampler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Works out where a sample time falls in the clip under the current settings: the two
   // neighbour frames, the curve count and the 16-bit blend weight. The frame count and the
   // curve count are saturated into their legal ranges, times before the start hold the first
   // frame, and a left frame at or past the end holds the last frame.
   function automatic void place_in_clip(input logic [VALUE_W-1:0] t,
                                         output int unsigned left, output int unsigned right,
                                         output int unsigned nc, output logic [WEIGHT_W-1:0] w);
      int unsigned nf;
      longint      d;
      logic [63:0] pos;
      nf = (cfg_frames == 0) ? 1 : (cfg_frames > DEF_MAX_FRAMES) ? DEF_MAX_FRAMES : cfg_frames;
      nc = (cfg_curves == 0) ? 1 : (cfg_curves > DEF_MAX_CURVES) ? DEF_MAX_CURVES : cfg_curves;
      d = longint'(signed'(t)) - longint'(signed'(cfg_start));
      if (d < 0) begin
         left = 0;
         right = 0;
         w = '0;
      end else begin
         // Q16.16 seconds times Q16.16 frames per second gives a Q32.32 frame position.
         pos = 64'(d) * {32'd0, cfg_fps};
         w = pos[31:16];
         if (pos[63:32] >= nf - 1) begin
            left = nf - 1;
            right = nf - 1;
         end else begin
            left = pos[63:32];
            right = left + 1;
         end
      end
   endfunction

   // Table words past the end of the table read as zero.
   function automatic longint peek_word(input int unsigned addr);
      if (addr >= TABLE_WORDS) return 0;
      return longint'(signed'(shadow_table[addr]));
   endfunction

   // Queues one blend per curve for an accepted sample. A row of the directed script may
   // give the value outright; it then applies to every curve.
   function automatic void expect_blends(input logic [VALUE_W-1:0] t, input bit typed,
                                         input logic [VALUE_W-1:0] want);
      int unsigned            left, right, nc;
      logic [WEIGHT_W-1:0]    w;
      longint                 a, b, blend;
      blend_type              e;
      place_in_clip(t, left, right, nc, w);
      for (int unsigned i = 0; i < nc; i++) begin
         a = peek_word(left * nc + i);
         b = peek_word(right * nc + i);
         // Round to nearest by adding one half, then floor; the arithmetic shift floors.
         blend = a + (((b - a) * longint'(w) + 32768) >>> 16);
         e.curve = CURVE_W'(i);
         e.value = typed ? want : blend[VALUE_W-1:0];
         e.last  = (i == nc - 1);
         due_blends.push_back(e);
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                  input logic [VALUE_W-1:0] want);
      $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
      error_count++;
   endtask

   // Compares the result accepted at this edge with the oldest prediction.
   task automatic check_blend();
      blend_type want;
      if (due_blends.size() == 0) begin
         report_mismatch("unexpected result", rsp_tdata, '0);
         return;
      end
      want = due_blends.pop_front();
      if (rsp_tuser !== want.curve)
         report_mismatch("curve number", VALUE_W'(rsp_tuser), VALUE_W'(want.curve));
      if (rsp_tdata !== want.value) report_mismatch("blended value", rsp_tdata, want.value);
      if (rsp_tlast !== want.last)
         report_mismatch("last curve flag", VALUE_W'(rsp_tlast), VALUE_W'(want.last));
   endtask

   // Offers one item after a random gap and waits until it is taken. The valid is only
   // lowered when a gap is wanted, so back-to-back items keep it high without a glitch.
   // Once the item is taken, the shadow table or the store of blends is brought up to date.
   task automatic send_item(input op_type op, input logic [WADDR_W-1:0] addr,
                            input logic [VALUE_W-1:0] value, input logic [VALUE_W-1:0] t,
                            input bit typed, input logic [VALUE_W-1:0] want);
      int gap;
      int pick;
      pick = $urandom_range(0, 99);
      if (sender_steady) gap = 0;
      else if (pick < 4) gap = $urandom_range(8, 30);
      else if (pick < 25) gap = $urandom_range(1, 3);
      else gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_DATA_W'({t, value, addr});
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (op == OP_WRITE) begin
         shadow_table[addr] = value;
         written[addr] = 1'b1;
      end else begin
         expect_blends(t, typed, want);
      end
   endtask

   // Before a sample, every table word it will read must hold a known value. Words that
   // were never written get a random value first; words past the table need nothing.
   task automatic prime_rows(input logic [VALUE_W-1:0] t);
      int unsigned         left, right, nc, addr;
      logic [WEIGHT_W-1:0] w;
      place_in_clip(t, left, right, nc, w);
      for (int unsigned i = 0; i < 2 * nc; i++) begin
         addr = (i < nc) ? left * nc + i : right * nc + (i - nc);
         if (addr < TABLE_WORDS && !written[addr])
            send_item(OP_WRITE, WADDR_W'(addr), $urandom, $urandom, 1'b0, '0);
      end
   endtask

   // Stops offering items and waits until every predicted blend has arrived and the block
   // has had time to finish any trailing write.
   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (due_blends.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Registers are only written while the block is idle.
   task automatic set_register(input csr_idx_type idx, input logic [VALUE_W-1:0] value);
      quiesce();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_START_TIME: cfg_start = value;
         CSR_FPS:        cfg_fps = value;
         CSR_FTOTAL:     cfg_frames = value[FTOTAL_W-1:0];
         CSR_CCOUNT:     cfg_curves = value[CCOUNT_W-1:0];
         default: ;
      endcase
   endtask

   // Result side. Each edge first checks the item accepted there, then decides whether to
   // take the next one. Most stalls are short, a few are long, and now and then a calm stretch
   // takes every result. On request it holds off for a long time so that the blend pipeline
   // fills and the block stops taking new items.
   initial begin
      int stall_left;
      int calm_left;
      int hold_left;
      int pick;
      stall_left = 0;
      calm_left = 0;
      hold_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) check_blend();
         if (hold_off_request) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_off_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (calm_left > 0) begin
            calm_left--;
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 3) stall_left = $urandom_range(10, 40);
            else if (pick < 20) stall_left = $urandom_range(0, 3);
            else if (pick < 23) calm_left = $urandom_range(50, 200);
            rsp_tready <= (pick >= 20);
         end
      end
   end

   // Watchdog: the run is hung when neither side moves an item for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("dense_keyframe_lerp_sampler_test: errors");
      $finish;
   end

   typedef enum logic {
      ROW_ITEM,
      ROW_CSR
   } step_kind_type;

   // One row of the directed script. A register row uses reg_idx and data; an item row uses
   // op, addr, data and stamp. When typed is set, every curve of the sample must equal want.
   typedef struct packed {
      step_kind_type       kind;
      op_type              op;
      csr_idx_type         reg_idx;
      logic [WADDR_W-1:0]  addr;
      logic [VALUE_W-1:0]  data;
      logic [VALUE_W-1:0]  stamp;
      bit                  typed;
      logic [VALUE_W-1:0]  want;
   } script_step_type;

   // The first rows run under the reset settings: two frames, one curve, 30 frames per
   // second. Frame 0 holds the largest value and frame 1 the smallest, so the blends in
   // between see the widest possible difference. Then one frame and one curve are forced by
   // zero counts, with extreme start times and rates. After that the counts saturate at
   // 1024 frames of 64 curves, which is four times the table, so late frames read as zero;
   // one sample straddles the last row inside the table and the first one past it.
   script_step_type opening_script [28] = '{
      '{ROW_ITEM, OP_WRITE,  CSR_START_TIME, 14'h0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{ROW_ITEM, OP_WRITE,  CSR_START_TIME, 14'h0001, 32'h8000_0000, 32'h0000_0000, 1'b0, 32'h0},
      // A time far before the start holds the first frame.
      '{ROW_ITEM, OP_SAMPLE, CSR_START_TIME, 14'h3FFF, 32'hFFFF_FFFF, 32'h8000_0000,
        1'b1, 32'h7FFF_FFFF},
      // A time far past the end holds the last frame.
      '{ROW_ITEM, OP_SAMPLE, CSR_START_TIME, 14'h0000, 32'h0000_0000, 32'h7FFF_FFFF,
        1'b1, 32'h8000_0000},
      // Exactly at the start the weight is zero.
      '{ROW_ITEM, OP_SAMPLE, CSR_START_TIME, 14'h0000, 32'h0000_0000, 32'h0000_0000,
        1'b1, 32'h7FFF_FFFF},
      '{ROW_ITEM, OP_SAMPLE, CSR_START_TIME, 14'h0000, 32'h0000_0000, 32'h0000_0444, 1'b0, 32'h0},
      '{ROW_ITEM, OP_SAMPLE, CSR_START_TIME, 14'h0000, 32'h0000_0000, 32'h0000_0888, 1'b0, 32'h0},
      '{ROW_ITEM, OP_WRITE,  CSR_START_TIME, 14'h3FFF, 32'h1234_5678, 32'h0000_0000, 1'b0, 32'h0},
      '{ROW_ITEM, OP_WRITE,  CSR_START_TIME, 14'h2AAA, 32'hA5A5_A5A5, 32'h5555_5555, 1'b0, 32'h0},
      '{ROW_ITEM, OP_WRITE,  CSR_START_TIME, 14'h1555, 32'h5A5A_5A5A, 32'hAAAA_AAAA, 1'b0, 32'h0},
      '{ROW_CSR,  OP_WRITE,  CSR_START_TIME, 14'h0000, 32'h8000_0000, 32'h0000_0000, 1'b0, 32'h0},
      '{ROW_CSR,  OP_WRITE,  CSR_FPS,        14'h0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0},
      '{ROW_CSR,  OP_WRITE,  CSR_FTOTAL,     14'h0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
      '{ROW_CSR,  OP_WRITE,  CSR_CCOUNT,     14'h0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
      // The largest time difference with a single frame still holds frame 0.
      '{ROW_ITEM, OP_SAMPLE, CSR_START_TIME, 14'h0000, 32'h0000_0000, 32'h7FFF_FFFF,
        1'b1, 32'h7FFF_FFFF},
      '{ROW_CSR,  OP_WRITE,  CSR_START_TIME, 14'h0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 32'h0},
      '{ROW_CSR,  OP_WRITE,  CSR_FPS,        14'h0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
      '{ROW_CSR,  OP_WRITE,  CSR_FTOTAL,     14'h0000, 32'h0000_07FF, 32'h0000_0000, 1'b0, 32'h0},
      '{ROW_CSR,  OP_WRITE,  CSR_CCOUNT,     14'h0000, 32'h0000_007F, 32'h0000_0000, 1'b0, 32'h0},
      '{ROW_ITEM, OP_SAMPLE, CSR_START_TIME, 14'h0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0},
      '{ROW_ITEM, OP_SAMPLE, CSR_START_TIME, 14'h0000, 32'h0000_0000, 32'h8000_0000, 1'b0, 32'h0},
      '{ROW_CSR,  OP_WRITE,  CSR_START_TIME, 14'h0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
      '{ROW_CSR,  OP_WRITE,  CSR_FPS,        14'h0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0},
      // The last frame lies past the table, so all 64 curves read as zero.
      '{ROW_ITEM, OP_SAMPLE, CSR_START_TIME, 14'h0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 32'h0},
      '{ROW_CSR,  OP_WRITE,  CSR_FPS,        14'h0000, 32'h0001_0000, 32'h0000_0000, 1'b0, 32'h0},
      // Halfway between the last row inside the table and the first one past it.
      '{ROW_ITEM, OP_SAMPLE, CSR_START_TIME, 14'h0000, 32'h0000_0000, 32'h00FF_8000, 1'b0, 32'h0},
      '{ROW_ITEM, OP_SAMPLE, CSR_START_TIME, 14'h0000, 32'h0000_0000, 32'h03FF_0000, 1'b1, 32'h0},
      '{ROW_ITEM, OP_SAMPLE, CSR_START_TIME, 14'h0000, 32'h0000_0000, 32'h03FE_C000, 1'b1, 32'h0}
   };

   // Main sequence: reset, the directed script, then random phases until enough items have
   // gone in, then the drain and the verdict.
   initial begin
      script_step_type s;
      int           phase;
      int           pick;
      logic [VALUE_W-1:0] t;
      logic [VALUE_W-1:0] start_v;
      logic [VALUE_W-1:0] fps_v;
      int           frames_v;
      int           curves_v;
      logic [63:0]  span;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_WRITE;
      csr_we     = 1'b0;
      csr_index  = CSR_START_TIME;
      csr_wdata  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_script[k]) begin
         s = opening_script[k];
         if (s.kind == ROW_CSR) begin
            set_register(s.reg_idx, s.data);
         end else begin
            if (s.op == OP_SAMPLE) prime_rows(s.stamp);
            send_item(s.op, s.addr, s.data, s.stamp, s.typed, s.want);
         end
      end

      // Each random phase picks new settings, mostly short clips of a few curves so that the
      // table stays small, and now and then the extremes. Inside a phase most samples land
      // in or just around the clip; a few are far before it or anywhere at all. The first
      // phase has the sender offering items without gaps while the receiver holds off.
      for (phase = 0; items_sent < TOTAL_ITEMS; phase++) begin
         pick = $urandom_range(0, 9);
         if (pick < 3) start_v = '0;
         else if (pick < 9) start_v = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
         else start_v = $urandom;
         case ($urandom_range(0, 4))
            0: fps_v = 32'h0001_0000;
            1: fps_v = 32'h001E_0000;
            2: fps_v = 32'h0000_8000;
            3: fps_v = $urandom_range(32'h0000_1000, 32'h0078_0000);
            default: fps_v = $urandom;
         endcase
         pick = $urandom_range(0, 9);
         if (pick < 6) frames_v = $urandom_range(2, 12);
         else if (pick < 8) frames_v = $urandom_range(0, 40);
         else frames_v = $urandom_range(0, 2047);
         pick = $urandom_range(0, 9);
         if (pick < 6) curves_v = $urandom_range(1, 4);
         else if (pick < 8) curves_v = $urandom_range(1, 16);
         else if (pick == 8) curves_v = 0;
         else curves_v = $urandom_range(17, 127);
         // Many curves over many frames would spend the run filling the table.
         if (curves_v > 16) frames_v = $urandom_range(0, 6);
         set_register(CSR_START_TIME, start_v);
         set_register(CSR_FPS, fps_v);
         set_register(CSR_FTOTAL, 32'(frames_v));
         set_register(CSR_CCOUNT, 32'(curves_v));

         sender_steady = (phase % 3 == 0);
         if (phase == 0) hold_off_request = 1'b1;

         repeat (25) begin
            if (items_sent >= TOTAL_ITEMS) break;
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
               send_item(OP_WRITE, WADDR_W'($urandom), $urandom, $urandom, 1'b0, '0);
            end else begin
               pick = $urandom_range(0, 9);
               if (pick == 0) begin
                  t = $urandom;
               end else if (pick == 1) begin
                  t = cfg_start - $urandom_range(1, 32'h0004_0000);
               end else begin
                  // Spread over the clip plus about three frames past its last frame.
                  if (cfg_fps == 0) span = 64'h0001_0000;
                  else span = ((64'(cfg_frames) + 64'd2) << 32) / {32'd0, cfg_fps};
                  if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
                  t = cfg_start + VALUE_W'((64'($urandom) * span) >> 32);
               end
               prime_rows(t);
               send_item(OP_SAMPLE, WADDR_W'($urandom), $urandom, t, 1'b0, '0);
            end
         end
      end

      quiesce();
      if (error_count == 0)
         $display("dense_keyframe_lerp_sampler_test: clean");
      else
         $display("dense_keyframe_lerp_sampler_test: errors");
      $finish;
   end

endmodule
